// File: rtl/sfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

	localparam int MAX_PATTERN_DEFAULT     = 8;
	localparam int MAX_REPLACEMENT_DEFAULT = 8;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int LEN_W       = 4;
	localparam int COUNT_W     = 33;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_BYTES       = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_LENGTH      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_BYTES  = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_REPLACEMENT_LENGTH = 2'd3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_string;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_present;
		logic       out_last;
		logic       length_overflow;
	} out_item_t;

	// Control part of one queued command: how many bytes to emit and whether
	// the command closes the string.
	typedef struct packed {
		logic [LEN_W-1:0] count;
		logic             last;
	} cmd_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/sfr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_front #(
	parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEFAULT,
	parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEFAULT,
	parameter int CMD_BYTES       = sfr_pkg::MAX_PATTERN_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write_en,
	input  wire logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            src_valid,
	output logic                                 src_ready,
	input  wire sfr_pkg::in_item_t               src_data,
	input  wire logic                            q_full,
	output logic                                 cmd_push,
	output sfr_pkg::cmd_ctrl_t                   cmd_ctrl,
	output logic [CMD_BYTES*8-1:0]               cmd_bytes
);
	import sfr_pkg::*;

	localparam int FILL_W = $clog2(MAX_PATTERN + 1);
	localparam int CMD_W  = CMD_BYTES * 8;

	logic [MAX_PATTERN-1:0][7:0]     needle_q;
	logic [MAX_REPLACEMENT-1:0][7:0] repl_q;
	logic [LEN_W-1:0]                needle_len_q;
	logic [LEN_W-1:0]                repl_len_q;
	logic [MAX_PATTERN-1:0][7:0]     win_q;
	logic [FILL_W-1:0]               fill_q;

	logic [LEN_W-1:0]            nl;
	logic [LEN_W-1:0]            rl;
	logic [FILL_W-1:0]           fill_eff;
	logic [FILL_W-1:0]           fill_new;
	logic [MAX_PATTERN-1:0][7:0] win_new;
	logic                        win_full;
	logic                        hit;
	logic                        pass;
	logic                        accept;

	assign nl = (needle_len_q > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : needle_len_q;
	assign rl = (repl_len_q > LEN_W'(MAX_REPLACEMENT)) ? LEN_W'(MAX_REPLACEMENT) : repl_len_q;
	assign pass = (nl == '0);

	assign src_ready = !q_full;
	assign accept    = src_valid && src_ready;

	// The new byte goes in at the current fill position of the window.
	always_comb begin
		fill_eff = (LEN_W'(fill_q) >= nl) ? '0 : fill_q;
		fill_new = fill_eff + FILL_W'(1);
		for (int i = 0; i < MAX_PATTERN; i++) begin
			win_new[i] = (FILL_W'(i) == fill_eff) ? src_data.data_byte : win_q[i];
		end
		win_full = (LEN_W'(fill_new) == nl);
		hit = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if ((LEN_W'(i) < nl) && (win_new[i] != needle_q[i])) begin
				hit = 1'b0;
			end
		end
	end

	always_comb begin
		cmd_ctrl.last  = src_data.end_of_string;
		cmd_bytes      = CMD_W'(win_new);
		cmd_ctrl.count = LEN_W'(1);
		cmd_push       = 1'b0;
		if (pass) begin
			cmd_bytes = CMD_W'(src_data.data_byte);
			cmd_push  = accept;
		end else if (win_full && hit) begin
			cmd_bytes      = CMD_W'(repl_q);
			cmd_ctrl.count = rl;
			// An empty replacement only yields a bare end marker at string end.
			cmd_push       = accept && ((rl != '0) || src_data.end_of_string);
		end else if (win_full) begin
			cmd_ctrl.count = src_data.end_of_string ? nl : LEN_W'(1);
			cmd_push       = accept;
		end else begin
			cmd_ctrl.count = LEN_W'(fill_new);
			cmd_push       = accept && src_data.end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_q     <= '0;
			repl_q       <= '0;
			needle_len_q <= '0;
			repl_len_q   <= '0;
			fill_q       <= '0;
		end else begin
			if (accept) begin
				if (pass || src_data.end_of_string || (win_full && hit)) begin
					fill_q <= '0;
				end else if (win_full) begin
					fill_q <= fill_new - FILL_W'(1);
				end else begin
					fill_q <= fill_new;
				end
			end
			if (cfg_write_en) begin
				unique case (cfg_index)
					CFG_NEEDLE_BYTES: begin
						needle_q <= cfg_data[MAX_PATTERN*8-1:0];
					end
					CFG_NEEDLE_LENGTH: begin
						needle_len_q <= cfg_data[LEN_W-1:0];
						fill_q       <= '0;
					end
					CFG_REPLACEMENT_BYTES: begin
						repl_q <= cfg_data[MAX_REPLACEMENT*8-1:0];
					end
					CFG_REPLACEMENT_LENGTH: begin
						repl_len_q <= cfg_data[LEN_W-1:0];
					end
				endcase
			end
		end
	end

	// On a mismatch the oldest byte leaves and the rest move down one lane.
	always_ff @(posedge clk) begin
		if (accept && !pass) begin
			if (win_full && !hit) begin
				win_q <= win_new >> 8;
			end else begin
				win_q <= win_new;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/sfr_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = sfr_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  valid,
	output logic [WIDTH-1:0]      head
);
	import sfr_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign valid   = (count_q != '0);
	assign head    = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// File: rtl/sfr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sfr_back #(
	parameter int CMD_BYTES = sfr_pkg::MAX_PATTERN_DEFAULT
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 count_clear,
	input  wire logic                 q_valid,
	output logic                      q_pop,
	input  wire sfr_pkg::cmd_ctrl_t   head_ctrl,
	input  wire logic [CMD_BYTES*8-1:0] head_bytes,
	output logic                      dst_valid,
	input  wire logic                 dst_ready,
	output sfr_pkg::out_item_t        dst_data
);
	import sfr_pkg::*;

	localparam int IDX_W = (CMD_BYTES > 1) ? $clog2(CMD_BYTES) : 1;

	logic [CMD_BYTES-1:0][7:0] bytes;
	logic [IDX_W-1:0]          idx_q;
	logic [COUNT_W-1:0]        cnt_q;
	logic                      dst_valid_q;
	out_item_t                 dst_data_q;

	logic               emit;
	logic               present;
	logic               cmd_done;
	logic               res_last;
	logic [COUNT_W-1:0] cnt_new;

	assign bytes    = head_bytes;
	assign emit     = q_valid && (!dst_valid_q || dst_ready);
	assign present  = (head_ctrl.count != '0);
	assign cmd_done = !present ||
		(LEN_W'(idx_q) == LEN_W'(head_ctrl.count - LEN_W'(1)));
	assign res_last = head_ctrl.last && cmd_done;
	// The top bit marks a saturated count of exactly 2^32 bytes.
	assign cnt_new  = cnt_q + COUNT_W'(present && !cnt_q[COUNT_W-1]);
	assign q_pop    = emit && cmd_done;

	assign dst_valid = dst_valid_q;
	assign dst_data  = dst_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			cnt_q       <= '0;
			dst_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				dst_valid_q <= 1'b1;
				idx_q       <= cmd_done ? '0 : idx_q + IDX_W'(1);
				cnt_q       <= res_last ? '0 : cnt_new;
			end else if (dst_ready) begin
				dst_valid_q <= 1'b0;
			end
			if (count_clear) begin
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			dst_data_q.out_byte        <= present ? bytes[idx_q] : 8'd0;
			dst_data_q.byte_present    <= present;
			dst_data_q.out_last        <= res_last;
			dst_data_q.length_overflow <= res_last && cnt_new[COUNT_W-1];
		end
	end

endmodule

`default_nettype wire

// File: rtl/stream_find_replace_top.sv
// A result is held in the command queue and then in the output register on its way out.
// Throughput, while the output is free: one request per cycle while each causes at most
// one result byte; a match emits its replacement at one byte per cycle from the back end.
// The two-entry command queue stalls the input only when it fills.
// Reset (arst_n low, asynchronous) clears the configuration, window fill, queue and
// output count; window bytes and data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module stream_find_replace_top #(
	parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEFAULT,
	parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEFAULT
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_write_en,
	input  wire logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            src_valid,
	output logic                                 src_ready,
	input  wire sfr_pkg::in_item_t               src_data,
	output logic                                 dst_valid,
	input  wire logic                            dst_ready,
	output sfr_pkg::out_item_t                   dst_data
);
	import sfr_pkg::*;

	localparam int CMD_BYTES = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
	localparam int Q_WIDTH   = $bits(cmd_ctrl_t) + CMD_BYTES * 8;

	cmd_ctrl_t              cmd_ctrl;
	logic [CMD_BYTES*8-1:0] cmd_bytes;
	logic                   cmd_push;
	logic                   q_full;
	logic                   q_valid;
	logic                   q_pop;
	logic [Q_WIDTH-1:0]     q_head;
	cmd_ctrl_t              head_ctrl;
	logic [CMD_BYTES*8-1:0] head_bytes;
	logic                   count_clear;

	assign count_clear = cfg_write_en && (cfg_index == CFG_NEEDLE_LENGTH);
	assign {head_ctrl, head_bytes} = q_head;

	sfr_front #(
		.MAX_PATTERN     (MAX_PATTERN),
		.MAX_REPLACEMENT (MAX_REPLACEMENT),
		.CMD_BYTES       (CMD_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.src_valid    (src_valid),
		.src_ready    (src_ready),
		.src_data     (src_data),
		.q_full       (q_full),
		.cmd_push     (cmd_push),
		.cmd_ctrl     (cmd_ctrl),
		.cmd_bytes    (cmd_bytes)
	);

	sfr_queue #(
		.WIDTH (Q_WIDTH),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data ({cmd_ctrl, cmd_bytes}),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.head      (q_head)
	);

	sfr_back #(
		.CMD_BYTES (CMD_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.count_clear (count_clear),
		.q_valid     (q_valid),
		.q_pop       (q_pop),
		.head_ctrl   (head_ctrl),
		.head_bytes  (head_bytes),
		.dst_valid   (dst_valid),
		.dst_ready   (dst_ready),
		.dst_data    (dst_data)
	);

	// A full queue can only build up behind an occupied output register.
	assert property (@(posedge clk) disable iff (!arst_n) !src_ready |-> dst_valid)
		else $error("command queue full while output register is empty");

	// The overflow flag only ever rides on the closing result of a string.
	assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.length_overflow |-> dst_data.out_last)
		else $error("length overflow reported on a result that is not last");

	// A result without a byte is the bare end marker and carries a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && !dst_data.byte_present |-> dst_data.out_last && (dst_data.out_byte == 8'd0))
		else $error("empty result that is not a clean end marker");

	// A request that finds the queue with room leaves it able to drain.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push && src_ready |=> q_valid || dst_valid)
		else $error("queued command lost");

endmodule

`default_nettype wire

// File: bench/tb_stream_find_replace_top.sv
`timescale 1ns / 1ps

module tb_stream_find_replace_top;
	import sfr_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 10;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_SHOWN    = 10;
	localparam int PAT_MAX      = 8;
	localparam int REP_MAX      = 8;

	typedef enum int {
		RX_ALWAYS,
		RX_HALF,
		RX_SPARSE,
		RX_MOSTLY
	} rx_mode_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   src_valid;
	logic                   src_ready;
	in_item_t               src_data;
	logic                   dst_valid;
	logic                   dst_ready;
	out_item_t              dst_data;

	// Shadow of the block's configuration and string state.
	logic [63:0] pat_bytes;
	logic [3:0]  pat_len;
	logic [63:0] rep_bytes;
	logic [3:0]  rep_len;
	logic [7:0]  window [PAT_MAX];
	int          window_fill;
	logic [32:0] out_count;

	out_item_t expected_out[$];
	int        error_count;
	int        cycle_count;
	int        burst_left;
	bit        hold_req;

	stream_find_replace_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.src_valid    (src_valid),
		.src_ready    (src_ready),
		.src_data     (src_data),
		.dst_valid    (dst_valid),
		.dst_ready    (dst_ready),
		.dst_data     (dst_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending", cycle_count,
				expected_out.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic void note_error(input string msg);
		error_count++;
		if (error_count <= MAX_SHOWN)
			$display("[%0t] %s", $realtime, msg);
	endfunction

	function automatic void clear_text_state();
		window_fill = 0;
		out_count   = '0;
	endfunction

	function automatic void push_out(input logic [7:0] b, input bit present, input bit last);
		out_item_t r;
		if (present && out_count < 33'h1_0000_0000)
			out_count++;
		r.out_byte        = present ? b : 8'h00;
		r.byte_present    = present;
		r.out_last        = last;
		r.length_overflow = last && (out_count > 33'h0_FFFF_FFFF);
		expected_out.push_back(r);
	endfunction

	// Works out every output byte that one source byte causes.
	function automatic void rewrite_byte(input in_item_t item);
		int nl;
		int rl;
		int i;
		bit hit;
		nl = (pat_len > PAT_MAX) ? PAT_MAX : int'(pat_len);
		rl = (rep_len > REP_MAX) ? REP_MAX : int'(rep_len);
		if (nl == 0) begin
			push_out(item.data_byte, 1'b1, item.end_of_string);
			if (item.end_of_string)
				clear_text_state();
			return;
		end
		if (window_fill >= nl)
			window_fill = 0;
		window[window_fill] = item.data_byte;
		window_fill++;
		if (window_fill == nl) begin
			hit = 1'b1;
			for (i = 0; i < nl; i++)
				if (window[i] != pat_bytes[8*i +: 8])
					hit = 1'b0;
			if (hit) begin
				for (i = 0; i < rl; i++)
					push_out(rep_bytes[8*i +: 8], 1'b1, item.end_of_string && i + 1 == rl);
				window_fill = 0;
				if (item.end_of_string && rl == 0)
					push_out(8'h00, 1'b0, 1'b1);
			end else begin
				push_out(window[0], 1'b1, item.end_of_string && window_fill == 1);
				for (i = 1; i < window_fill; i++)
					window[i-1] = window[i];
				window_fill--;
			end
		end
		if (item.end_of_string) begin
			for (i = 0; i < window_fill; i++)
				push_out(window[i], 1'b1, i + 1 == window_fill);
			clear_text_state();
		end
	endfunction

	task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= value;
		case (idx)
			CFG_NEEDLE_BYTES: pat_bytes = value;
			CFG_NEEDLE_LENGTH: begin
				pat_len = value[3:0];
				clear_text_state();
			end
			CFG_REPLACEMENT_BYTES: rep_bytes = value;
			CFG_REPLACEMENT_LENGTH: rep_len = value[3:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_all_cfg(input logic [63:0] needle, input logic [3:0] nlen,
		input logic [63:0] repl, input logic [3:0] rlen);
		write_cfg(CFG_NEEDLE_BYTES, needle);
		write_cfg(CFG_NEEDLE_LENGTH, {60'd0, nlen});
		write_cfg(CFG_REPLACEMENT_BYTES, repl);
		write_cfg(CFG_REPLACEMENT_LENGTH, {60'd0, rlen});
	endtask

	// Offers one request and returns at the edge where it is accepted.
	task automatic send_item(input logic [7:0] b, input bit eos);
		in_item_t item;
		int gap;
		item.data_byte     = b;
		item.end_of_string = eos;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 5);
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 16);
		end
		burst_left--;
		rewrite_byte(item);
		src_valid <= 1'b1;
		src_data  <= item;
		@(posedge clk);
		while (!src_ready)
			@(posedge clk);
	endtask

	task automatic send_text(input logic [7:0] text[$], input bit close);
		int i;
		for (i = 0; i < text.size(); i++)
			send_item(text[i], close && i + 1 == text.size());
	endtask

	// Bytes held in the window cause no output, so after the queue empties we
	// still wait out DRAIN_CYCLES before touching its registers.
	task automatic wait_drain();
		src_valid <= 1'b0;
		while (expected_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly well-formed text around the needle, with broken prefixes and noise.
	function automatic void build_text(output logic [7:0] text[$]);
		int nl;
		int target;
		int i;
		int cut;
		nl     = (pat_len > PAT_MAX) ? PAT_MAX : int'(pat_len);
		target = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
		text   = {};
		while (text.size() < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					for (i = 0; i < nl; i++)
						text.push_back(pat_bytes[8*i +: 8]);
					if (nl == 0)
						text.push_back(8'($urandom_range(0, 255)));
				end
				4, 5: begin
					cut = (nl > 1) ? $urandom_range(1, nl - 1) : 0;
					for (i = 0; i < cut; i++)
						text.push_back(pat_bytes[8*i +: 8]);
					text.push_back(8'($urandom_range(0, 255)));
				end
				6, 7: text.push_back(pat_bytes[8*$urandom_range(0, PAT_MAX - 1) +: 8]);
				default: text.push_back(8'($urandom_range(0, 255)));
			endcase
		end
	endfunction

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && dst_valid && dst_ready) begin
			if (expected_out.size() == 0) begin
				note_error($sformatf("unexpected result byte=%h present=%b last=%b ovf=%b",
					dst_data.out_byte, dst_data.byte_present, dst_data.out_last,
					dst_data.length_overflow));
			end else begin
				want = expected_out.pop_front();
				if (dst_data.out_byte !== want.out_byte
					|| dst_data.byte_present !== want.byte_present
					|| dst_data.out_last !== want.out_last
					|| dst_data.length_overflow !== want.length_overflow)
					note_error($sformatf({"mismatch: expected byte=%h present=%b last=%b ovf=%b,",
						" got byte=%h present=%b last=%b ovf=%b"},
						want.out_byte, want.byte_present, want.out_last, want.length_overflow,
						dst_data.out_byte, dst_data.byte_present, dst_data.out_last,
						dst_data.length_overflow));
			end
		end
	end

	// Receiver: changes its stall pattern at random intervals and holds off
	// completely for HOLD_CYCLES when asked to.
	initial begin : receiver
		rx_mode_t mode;
		int mode_left;
		int stall_left;
		mode       = RX_ALWAYS;
		mode_left  = 0;
		stall_left = 0;
		dst_ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (mode_left == 0) begin
				mode      = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(16, 96);
			end
			mode_left--;
			if (hold_req) begin
				hold_req   = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left > 0) begin
				stall_left--;
				dst_ready <= 1'b0;
			end else begin
				case (mode)
					RX_ALWAYS: dst_ready <= 1'b1;
					RX_HALF:   dst_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: dst_ready <= ($urandom_range(0, 3) == 0);
					default:   dst_ready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic test_passthrough_at_reset();
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(8'h5A, 1'b1);
		wait_drain();
	endtask

	task automatic test_field_extremes();
		set_all_cfg(64'h0000_0000_0000_00FF, 4'd2, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'h41, 1'b1);
		wait_drain();
		// A match on the final byte with nothing to put in its place leaves
		// only the end marker.
		write_cfg(CFG_REPLACEMENT_LENGTH, 64'd0);
		send_item(8'hFF, 1'b0);
		send_item(8'h00, 1'b1);
		wait_drain();
	endtask

	task automatic test_length_above_max();
		int i;
		set_all_cfg(64'h0, 4'd15, 64'h0123_4567_89AB_CDEF, 4'd15);
		for (i = 0; i < PAT_MAX; i++)
			send_item(8'h00, i == PAT_MAX - 1);
		send_item(8'h11, 1'b0);
		send_item(8'h22, 1'b0);
		send_item(8'h33, 1'b1);
		wait_drain();
	endtask

	task automatic test_midstring_rewrite();
		set_all_cfg(64'h0000_0000_0063_6261, 4'd3, 64'h0000_0000_0000_4443, 4'd2);
		send_item(8'h61, 1'b0);
		send_item(8'h62, 1'b0);
		wait_drain();
		// Rewriting the needle length drops what the window holds.
		write_cfg(CFG_NEEDLE_LENGTH, 64'd3);
		send_item(8'h63, 1'b1);
		wait_drain();
		send_item(8'h61, 1'b0);
		send_item(8'h62, 1'b0);
		wait_drain();
		write_cfg(CFG_REPLACEMENT_BYTES, 64'h0000_0000_0000_005A);
		send_item(8'h63, 1'b1);
		wait_drain();
	endtask

	task automatic test_backpressure_fill();
		int i;
		set_all_cfg(64'h0000_0000_0000_0078, 4'd1, 64'h8877_6655_4433_2211, 4'd8);
		hold_req   = 1'b1;
		burst_left = 40;
		for (i = 0; i < 30; i++)
			send_item(8'h78, i == 29);
		wait_drain();
	endtask

	task automatic test_random_strings();
		logic [7:0]  text[$];
		logic [7:0]  sym_a;
		logic [7:0]  sym_b;
		logic [63:0] needle;
		logic [3:0]  nlen;
		logic [3:0]  rlen;
		int phase;
		int sent;
		int i;
		for (phase = 0; phase < 8; phase++) begin
			sym_a = 8'($urandom_range(0, 255));
			sym_b = 8'($urandom_range(0, 255));
			needle = {$urandom, $urandom};
			// A two-symbol needle makes overlapping and near matches common.
			if (phase % 2 == 0)
				for (i = 0; i < PAT_MAX; i++)
					needle[8*i +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
			case (phase)
				0: begin nlen = 4'd1; rlen = 4'd0; end
				1: begin nlen = 4'd2; rlen = 4'd8; end
				2: begin nlen = 4'd8; rlen = 4'd1; end
				3: begin nlen = 4'd15; rlen = 4'd15; end
				4: begin nlen = 4'd3; rlen = 4'd3; end
				5: begin nlen = 4'd0; rlen = 4'($urandom_range(0, 8)); end
				default: begin
					nlen = 4'($urandom_range(0, 15));
					rlen = 4'($urandom_range(0, 15));
				end
			endcase
			set_all_cfg(needle, nlen, {$urandom, $urandom}, rlen);
			sent = 0;
			while (sent < 50) begin
				build_text(text);
				send_text(text, 1'b1);
				sent += text.size();
			end
			wait_drain();
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_write_en = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		src_valid    = 1'b0;
		src_data     = '0;
		pat_bytes    = '0;
		pat_len      = '0;
		rep_bytes    = '0;
		rep_len      = '0;
		error_count  = 0;
		cycle_count  = 0;
		burst_left   = 0;
		hold_req     = 1'b0;
		clear_text_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_passthrough_at_reset();
		test_field_extremes();
		test_length_above_max();
		test_midstring_rewrite();
		test_backpressure_fill();
		test_random_strings();

		wait_drain();
		repeat (20) @(posedge clk);
		if (expected_out.size() != 0)
			note_error($sformatf("%0d expected results never arrived", expected_out.size()));
		if (error_count > MAX_SHOWN)
			$display("%0d further errors not shown", error_count - MAX_SHOWN);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
